### design/qsts_pkg.sv
`timescale 1ns / 1ps

package qsts_pkg;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SKIP,
      PH_COMMENT,
      PH_OPEN1,
      PH_BODY,
      PH_ESC,
      PH_OPEN2,
      PH_RAW
   } phase_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam logic [1:0] RAW_CLOSE = 2'd3;

   localparam logic [1:0] ROLE_SKIP = 2'd0;
   localparam logic [1:0] ROLE_TAKE = 2'd1;
   localparam logic [1:0] ROLE_NONE = 2'd2;

   localparam logic [1:0] OUT_NONE = 2'd0;
   localparam logic [1:0] OUT_STR  = 2'd1;
   localparam logic [1:0] OUT_RAW  = 2'd2;

endpackage

### design/qsts_req_if.sv
`timescale 1ns / 1ps

interface qsts_req_if;
   logic       valid;
   logic       ready;
   logic       begin_scan;
   logic       want_string;
   logic       want_raw;
   logic [7:0] char_in;
   logic       end_of_text;

   modport source (
      output valid, begin_scan, want_string, want_raw, char_in, end_of_text,
      input  ready
   );
   modport sink (
      input  valid, begin_scan, want_string, want_raw, char_in, end_of_text,
      output ready
   );
endinterface

### design/qsts_rsp_if.sv
`timescale 1ns / 1ps

interface qsts_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] byte_role;
   logic       finished;
   logic [1:0] outcome;

   modport source (
      output valid, byte_role, finished, outcome,
      input  ready
   );
   modport sink (
      input  valid, byte_role, finished, outcome,
      output ready
   );
endinterface

### design/quoted_string_token_scanner_core.sv
`timescale 1ns / 1ps

// Byte-at-a-time token scanner: takes one request per clock and answers each with one
// response telling whether the byte was skipped (blank or ';' comment), taken into the
// token, or not taken, plus whether the scan ended and with which token kind. A request
// with begin_scan set starts a fresh scan, abandoning any scan in progress. The scan
// state is updated by a few byte compares in the cycle the request is accepted, and the
// response appears from the output register on the next cycle; a new request is taken
// whenever that register is empty or being emptied, so the sustained rate is one byte
// per clock while the response side keeps accepting responses.
module quoted_string_token_scanner_core (
   input logic       clock,
   input logic       reset,
   qsts_req_if.sink  req_stream,
   qsts_rsp_if.source rsp_stream
);
   import qsts_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] closing_quotes_ff, closing_quotes_in;
   logic       string_enabled_ff, raw_enabled_ff;
   logic       rsp_valid_ff;
   logic [1:0] byte_role_ff, outcome_ff;
   logic       finished_ff;

   logic       accept;
   logic       abort_start;
   phase_type  cur_phase;
   logic       str_en, raw_en;
   logic [7:0] c;
   logic       eot;
   logic       is_blank, is_quote;
   logic [1:0] quotes_inc;
   logic [1:0] role;
   logic       fin;
   logic [1:0] res;

   assign req_stream.ready = !rsp_valid_ff || rsp_stream.ready;
   assign accept = req_stream.valid && req_stream.ready;

   assign c   = req_stream.char_in;
   assign eot = req_stream.end_of_text;
   assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
   assign is_quote = !eot && (c == CH_QUOTE);
   assign quotes_inc = closing_quotes_ff + 2'd1;

   // a start request overrides the stored scan
   assign str_en = req_stream.begin_scan ? req_stream.want_string : string_enabled_ff;
   assign raw_en = req_stream.begin_scan ? req_stream.want_raw : raw_enabled_ff;
   assign abort_start = req_stream.begin_scan && !req_stream.want_string
                        && !req_stream.want_raw;
   assign cur_phase = req_stream.begin_scan ? PH_SKIP : phase_ff;

   // next state
   always_comb begin
      phase_in = cur_phase;
      if (abort_start) begin
         phase_in = PH_IDLE;
      end else begin
         unique case (cur_phase)
            PH_IDLE: phase_in = PH_IDLE;
            PH_SKIP: begin
               priority if (eot)          phase_in = PH_IDLE;
               else if (is_blank)         phase_in = PH_SKIP;
               else if (c == CH_SEMI)     phase_in = PH_COMMENT;
               else if (c == CH_QUOTE)    phase_in = PH_OPEN1;
               else                       phase_in = PH_IDLE;
            end
            PH_COMMENT: begin
               priority if (eot)          phase_in = PH_IDLE;
               else if (c == CH_NL)       phase_in = PH_SKIP;
               else                       phase_in = PH_COMMENT;
            end
            PH_OPEN1: begin
               priority if (eot)          phase_in = PH_IDLE;
               else if (c == CH_QUOTE)    phase_in = PH_OPEN2;
               else if (!str_en)          phase_in = PH_IDLE;
               else if (c == CH_BSLASH)   phase_in = PH_ESC;
               else if (c == CH_NL)       phase_in = PH_IDLE;
               else                       phase_in = PH_BODY;
            end
            PH_BODY: begin
               priority if (eot)          phase_in = PH_IDLE;
               else if (c == CH_BSLASH)   phase_in = PH_ESC;
               else if (c == CH_QUOTE)    phase_in = PH_IDLE;
               else if (c == CH_NL)       phase_in = PH_IDLE;
               else                       phase_in = PH_BODY;
            end
            PH_ESC: phase_in = eot ? PH_IDLE : PH_BODY;
            PH_OPEN2: phase_in = (is_quote && raw_en) ? PH_RAW : PH_IDLE;
            PH_RAW: begin
               priority if (eot)          phase_in = PH_IDLE;
               else if (c == CH_QUOTE && quotes_inc == RAW_CLOSE) phase_in = PH_IDLE;
               else                       phase_in = PH_RAW;
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      // quote run only survives inside a raw body
      if (cur_phase == PH_RAW && phase_in == PH_RAW && is_quote) begin
         closing_quotes_in = quotes_inc;
      end else begin
         closing_quotes_in = 2'd0;
      end
   end

   // response fields
   always_comb begin
      role = ROLE_NONE;
      fin  = 1'b0;
      res  = OUT_NONE;
      if (abort_start) begin
         fin = 1'b1;
      end else begin
         unique case (cur_phase)
            PH_IDLE: begin
               role = ROLE_NONE;
            end
            PH_SKIP: begin
               priority if (eot)                           fin  = 1'b1;
               else if (is_blank || c == CH_SEMI)          role = ROLE_SKIP;
               else if (c == CH_QUOTE)                     role = ROLE_TAKE;
               else                                        fin  = 1'b1;
            end
            PH_COMMENT: begin
               if (eot) fin  = 1'b1;
               else     role = ROLE_SKIP;
            end
            PH_OPEN1, PH_BODY: begin
               priority if (eot) begin
                  fin = 1'b1;
               end else if (cur_phase == PH_OPEN1 && c == CH_QUOTE) begin
                  role = ROLE_TAKE;
               end else if (cur_phase == PH_OPEN1 && !str_en) begin
                  fin = 1'b1;
               end else if (c == CH_QUOTE) begin
                  role = ROLE_TAKE;
                  fin  = 1'b1;
                  res  = OUT_STR;
               end else if (c == CH_NL) begin
                  fin = 1'b1;
               end else begin
                  role = ROLE_TAKE;
               end
            end
            PH_ESC: begin
               if (eot) fin  = 1'b1;
               else     role = ROLE_TAKE;
            end
            PH_OPEN2: begin
               priority if (is_quote && raw_en) begin
                  role = ROLE_TAKE;
               end else if (is_quote) begin
                  fin = 1'b1;
               end else begin
                  // empty string closes on the byte after the second quote
                  fin = 1'b1;
                  res = str_en ? OUT_STR : OUT_NONE;
               end
            end
            PH_RAW: begin
               priority if (eot) begin
                  fin = 1'b1;
               end else if (c == CH_QUOTE && quotes_inc == RAW_CLOSE) begin
                  role = ROLE_TAKE;
                  fin  = 1'b1;
                  res  = OUT_RAW;
               end else begin
                  role = ROLE_TAKE;
               end
            end
            default: begin
               role = ROLE_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         closing_quotes_ff <= 2'd0;
         string_enabled_ff <= 1'b0;
         raw_enabled_ff    <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff          <= phase_in;
            closing_quotes_ff <= closing_quotes_in;
            string_enabled_ff <= str_en;
            raw_enabled_ff    <= raw_en;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_stream.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_role_ff <= role;
         finished_ff  <= fin;
         outcome_ff   <= res;
      end
   end

   assign rsp_stream.valid     = rsp_valid_ff;
   assign rsp_stream.byte_role = byte_role_ff;
   assign rsp_stream.finished  = finished_ff;
   assign rsp_stream.outcome   = outcome_ff;

endmodule

### tb/tb_quoted_string_token_scanner_core.sv
`timescale 1ns / 1ps

module tb_quoted_string_token_scanner_core;
   import qsts_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SCAN_ITEMS = 1350;

   typedef struct packed {
      logic       begin_scan;
      logic       want_string;
      logic       want_raw;
      logic [7:0] char_in;
      logic       end_of_text;
   } scan_req_type;

   typedef struct packed {
      logic [1:0] byte_role;
      logic       finished;
      logic [1:0] outcome;
   } scan_rsp_type;

   typedef struct packed {
      logic         known;
      scan_req_type item;
      scan_rsp_type rsp;
   } script_row_type;

   logic clock;
   logic reset;

   qsts_req_if req_bus ();
   qsts_rsp_if rsp_bus ();

   quoted_string_token_scanner_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_bus.sink),
      .rsp_stream (rsp_bus.source)
   );

   // scanner state as the testbench sees it
   phase_type  scan_phase;
   logic [1:0] quote_run;
   logic       str_on;
   logic       raw_on;

   scan_rsp_type   expected_rsp [$];
   scan_rsp_type   want_rsp;
   script_row_type script [$];
   int             errors;
   int             scan_items;
   int             cycle_count;
   int unsigned    stall_left;
   bit             calm;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // advances the scanner state by one byte and returns its response
   function automatic scan_rsp_type scan_byte(input scan_req_type item);
      scan_rsp_type res;
      logic [7:0]   c;
      logic         blank;
      logic         at_body;
      res = '{ROLE_NONE, 1'b0, OUT_NONE};
      c = item.char_in;
      blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
      at_body = 1'b0;
      if (item.begin_scan) begin
         str_on = item.want_string;
         raw_on = item.want_raw;
         quote_run = 2'd0;
         scan_phase = PH_SKIP;
      end
      if (item.begin_scan && !str_on && !raw_on) begin
         res.finished = 1'b1;
      end else if (item.end_of_text && scan_phase != PH_OPEN2 && scan_phase != PH_IDLE) begin
         res.finished = 1'b1;
      end else begin
         case (scan_phase)
            PH_SKIP: begin
               if (blank) begin
                  res.byte_role = ROLE_SKIP;
               end else if (c == CH_SEMI) begin
                  scan_phase = PH_COMMENT;
                  res.byte_role = ROLE_SKIP;
               end else if (c == CH_QUOTE) begin
                  scan_phase = PH_OPEN1;
                  res.byte_role = ROLE_TAKE;
               end else begin
                  res.finished = 1'b1;
               end
            end
            PH_COMMENT: begin
               if (c == CH_NL) scan_phase = PH_SKIP;
               res.byte_role = ROLE_SKIP;
            end
            PH_OPEN1: begin
               if (c == CH_QUOTE) begin
                  scan_phase = PH_OPEN2;
                  res.byte_role = ROLE_TAKE;
               end else if (!str_on) begin
                  res.finished = 1'b1;
               end else begin
                  at_body = 1'b1;
               end
            end
            PH_BODY: at_body = 1'b1;
            PH_ESC: begin
               scan_phase = PH_BODY;
               res.byte_role = ROLE_TAKE;
            end
            PH_OPEN2: begin
               if (!item.end_of_text && c == CH_QUOTE) begin
                  if (raw_on) begin
                     scan_phase = PH_RAW;
                     quote_run = 2'd0;
                     res.byte_role = ROLE_TAKE;
                  end else begin
                     res.finished = 1'b1;
                  end
               end else begin
                  // empty string closes on the byte after it
                  res.finished = 1'b1;
                  res.outcome = str_on ? OUT_STR : OUT_NONE;
               end
            end
            PH_RAW: begin
               res.byte_role = ROLE_TAKE;
               if (c == CH_QUOTE) begin
                  quote_run = quote_run + 2'd1;
                  if (quote_run == RAW_CLOSE) begin
                     res.finished = 1'b1;
                     res.outcome = OUT_RAW;
                  end
               end else begin
                  quote_run = 2'd0;
               end
            end
            default: scan_phase = PH_IDLE;
         endcase
      end
      if (at_body) begin
         if (c == CH_BSLASH) begin
            scan_phase = PH_ESC;
            res.byte_role = ROLE_TAKE;
         end else if (c == CH_QUOTE) begin
            res.byte_role = ROLE_TAKE;
            res.finished = 1'b1;
            res.outcome = OUT_STR;
         end else if (c == CH_NL) begin
            res.finished = 1'b1;
         end else begin
            scan_phase = PH_BODY;
            res.byte_role = ROLE_TAKE;
         end
      end
      if (res.finished) begin
         scan_phase = PH_IDLE;
         quote_run = 2'd0;
      end
      return res;
   endfunction

   function automatic script_row_type row_known(input logic b, input logic s, input logic w,
                                                input logic [7:0] c, input logic eot,
                                                input logic [1:0] role, input logic fin,
                                                input logic [1:0] res);
      return '{1'b1, '{b, s, w, c, eot}, '{role, fin, res}};
   endfunction

   function automatic script_row_type row_pred(input logic b, input logic s, input logic w,
                                               input logic [7:0] c, input logic eot);
      return '{1'b0, '{b, s, w, c, eot}, '{ROLE_NONE, 1'b0, OUT_NONE}};
   endfunction

   function automatic logic [7:0] text_byte();
      case ($urandom_range(0, 9))
         0: return CH_BSLASH;
         1, 2: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h20, 8'h7E));
      endcase
   endfunction

   // leaves valid high when the next request follows at once
   task automatic send_req(input scan_req_type item, input logic known,
                           input scan_rsp_type known_rsp);
      int unsigned  gap;
      scan_rsp_type predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.begin_scan <= item.begin_scan;
      req_bus.want_string <= item.want_string;
      req_bus.want_raw <= item.want_raw;
      req_bus.char_in <= item.char_in;
      req_bus.end_of_text <= item.end_of_text;
      do @(posedge clock); while (!req_bus.ready);
      if (item.begin_scan || scan_phase != PH_IDLE) scan_items++;
      predicted = scan_byte(item);
      expected_rsp.push_back(known ? known_rsp : predicted);
   endtask

   // one scan: blanks and comments, then a token, sometimes cut short
   task automatic run_scan();
      logic [8:0] text [$];
      logic [1:0] wants;
      int         n;
      int         k;
      int         cut;
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 3))
            0: text.push_back({CH_SPACE, 1'b0});
            1: text.push_back({CH_TAB, 1'b0});
            2: text.push_back({CH_CR, 1'b0});
            default: text.push_back({CH_NL, 1'b0});
         endcase
      end
      if ($urandom_range(0, 3) == 0) begin
         text.push_back({CH_SEMI, 1'b0});
         repeat ($urandom_range(0, 6)) text.push_back({8'($urandom_range(0, 255)), 1'b0});
         text.push_back({CH_NL, 1'b0});
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            text.push_back({CH_QUOTE, 1'b0});
            repeat ($urandom_range(0, 10)) text.push_back({text_byte(), 1'b0});
            if ($urandom_range(0, 9) == 0) text.push_back({CH_NL, 1'b0});
            else text.push_back({CH_QUOTE, 1'b0});
         end
         5, 6: begin
            repeat (2) text.push_back({CH_QUOTE, 1'b0});
            text.push_back({text_byte(), 1'b0});
         end
         7, 8: begin
            repeat (3) text.push_back({CH_QUOTE, 1'b0});
            repeat ($urandom_range(0, 8)) begin
               // short quote runs inside the raw body must not close it
               if ($urandom_range(0, 3) == 0) begin
                  n = $urandom_range(1, 2);
                  repeat (n) text.push_back({CH_QUOTE, 1'b0});
               end else begin
                  text.push_back({text_byte(), 1'b0});
               end
            end
            repeat (3) text.push_back({CH_QUOTE, 1'b0});
         end
         default: text.push_back({8'($urandom_range(0, 255)), 1'b0});
      endcase
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(0, text.size() - 1);
         while (text.size() > cut) void'(text.pop_back());
         text.push_back({8'($urandom_range(0, 255)), 1'b1});
      end
      case ($urandom_range(0, 7))
         0: wants = 2'b00;
         1, 2: wants = 2'b10;
         3, 4: wants = 2'b01;
         default: wants = 2'b11;
      endcase
      send_req({1'b1, wants, text[0]}, 1'b0, '0);
      k = 1;
      while (scan_phase != PH_IDLE && k < text.size()) begin
         // leave the scan open so the next one restarts it
         if ($urandom_range(0, 59) == 0) return;
         send_req({1'b0, 2'($urandom_range(0, 3)), text[k]}, 1'b0, '0);
         k++;
      end
      if (scan_phase != PH_IDLE) begin
         send_req({1'b0, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b1}, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response role %0d finished %0d outcome %0d", $time,
                     rsp_bus.byte_role, rsp_bus.finished, rsp_bus.outcome);
            errors++;
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_bus.byte_role !== want_rsp.byte_role) begin
               $display("%0t: byte_role expected %0d actual %0d", $time,
                        want_rsp.byte_role, rsp_bus.byte_role);
               errors++;
            end
            if (rsp_bus.finished !== want_rsp.finished) begin
               $display("%0t: finished expected %0d actual %0d", $time,
                        want_rsp.finished, rsp_bus.finished);
               errors++;
            end
            if (rsp_bus.outcome !== want_rsp.outcome) begin
               $display("%0t: outcome expected %0d actual %0d", $time,
                        want_rsp.outcome, rsp_bus.outcome);
               errors++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.begin_scan = 1'b0;
      req_bus.want_string = 1'b0;
      req_bus.want_raw = 1'b0;
      req_bus.char_in = 8'h00;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      cycle_count = 0;
      errors = 0;
      calm = 1'b0;
      scan_phase = PH_IDLE;
      quote_run = 2'd0;
      str_on = 1'b0;
      raw_on = 1'b0;

      script = '{
         row_known(1'b0, 1'b0, 1'b0, "a", 1'b0, ROLE_NONE, 1'b0, OUT_NONE),
         row_known(1'b1, 1'b0, 1'b0, "a", 1'b0, ROLE_NONE, 1'b1, OUT_NONE),
         row_known(1'b1, 1'b1, 1'b1, CH_SPACE, 1'b0, ROLE_SKIP, 1'b0, OUT_NONE),
         row_pred(1'b0, 1'b0, 1'b0, CH_SEMI, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, 8'hFF, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_NL, 1'b0),
         row_pred(1'b0, 1'b1, 1'b1, CH_TAB, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_BSLASH, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0),
         row_known(1'b0, 1'b0, 1'b0, CH_NL, 1'b0, ROLE_NONE, 1'b1, OUT_NONE),
         row_pred(1'b1, 1'b1, 1'b0, CH_QUOTE, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0),
         row_known(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0, ROLE_NONE, 1'b1, OUT_NONE),
         row_pred(1'b1, 1'b0, 1'b1, CH_QUOTE, 1'b0),
         row_known(1'b0, 1'b0, 1'b0, "a", 1'b0, ROLE_NONE, 1'b1, OUT_NONE),
         row_pred(1'b1, 1'b1, 1'b1, CH_QUOTE, 1'b0),
         row_pred(1'b1, 1'b1, 1'b1, CH_QUOTE, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0),
         row_known(1'b0, 1'b0, 1'b0, 8'h00, 1'b1, ROLE_NONE, 1'b1, OUT_STR),
         row_pred(1'b1, 1'b0, 1'b1, CH_QUOTE, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, 8'h00, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0),
         row_pred(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0),
         row_known(1'b0, 1'b0, 1'b0, CH_QUOTE, 1'b0, ROLE_TAKE, 1'b1, OUT_RAW),
         row_known(1'b1, 1'b1, 1'b1, "a", 1'b0, ROLE_NONE, 1'b1, OUT_NONE),
         row_known(1'b1, 1'b1, 1'b1, CH_QUOTE, 1'b1, ROLE_NONE, 1'b1, OUT_NONE)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_req(script[i].item, script[i].known, script[i].rsp);

      scan_items = 0;
      while (scan_items < SCAN_ITEMS) begin
         if ($urandom_range(0, 24) == 0) calm = !calm;
         run_scan();
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) send_req({1'b0, 11'($urandom)}, 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
